// ----- src/tcw_pkg.sv -----
package tcw_pkg;

    // Command codes carried on the kind field.
    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_SETPOS = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    // Character codes with special meaning.
    localparam logic [7:0] CODE_NUL       = 8'd0;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_SPACE     = 8'd32;

    // Foreground nibble used when the screen is cleared.
    localparam logic [3:0] ATTR_CLEAR_FORE = 4'hF;

    // One screen cell: attribute in the high byte, character in the low byte.
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] chr;
    } t_cell;

endpackage

// ----- src/tcw_cell_ram.sv -----
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tcw_pkg::t_cell  i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output tcw_pkg::t_cell  o_rdata
);
    import tcw_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data is registered, so it appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/text_console_writer_top.sv -----
// Text console writer: a screen of COLUMNS x ROWS character cells with a cursor.
// A command transaction is taken at a rising edge where start is high and busy
// is low. The kind field selects put character, clear screen, set cursor
// position or read cell. Every command gives exactly one result, shown for one
// cycle with o_done high: the cursor column, row and linear offset after the
// command, plus the cell contents for a read (zero for other commands).
// A stored character, a newline without scroll, set position and a read past
// the last cell are answered straight from idle; a backspace and a read of a
// cell go through the cell memory's registered read port first (S_BS, S_READ).
// A clear walks the whole cell memory one cell per cycle (S_FILL); a scrolling
// character copies each row up one row (S_SCROLL) and then blanks the last row
// (S_FILL). busy is high only while the sequencer is out of idle and drops
// in the strobe cycle, so a command answered straight from idle never raises
// busy, and a new command can be taken in any strobe cycle.
// Results cannot be held off: the receiver must take o_done when it comes.
// After reset the block runs a clearing pass that writes zero into all
// COLUMNS*ROWS cells; busy stays high until it is finished and the
// cursor starts at column 0, row 0.
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [3:0]  i_fore_color,
    input  logic [3:0]  i_back_color,
    input  logic [6:0]  i_new_column,
    input  logic [4:0]  i_new_row,
    input  logic [10:0] i_read_index,
    output logic        o_done,
    output logic [6:0]  o_cursor_column,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_offset,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attr
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);

    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_END = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW:0]   SRC_START  = (AW+1)'(COLUMNS);
    localparam logic [AW:0]   SRC_STOP   = (AW+1)'(CELLS);

    // Sequencer states.
    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_BS     = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW:0]   r_addr, n_addr;
    logic [AW-1:0] r_waddr, n_waddr;
    logic          r_wpend, n_wpend;
    t_cell         r_fill, n_fill;
    logic          r_done, n_done;
    t_cell         r_cell, n_cell;

    logic          w_accept;
    logic          w_step_row;
    logic [AW-1:0] w_off;
    logic [AW-1:0] w_bs_off;
    logic [CW-1:0] w_bs_col;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_cell         w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    t_cell         w_rdata;

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_accept = start && (r_state == S_IDLE);

    // Linear cursor offset, and the cell a backspace lands on.
    assign w_off    = AW'(r_row * COLUMNS) + AW'(r_col);
    assign w_bs_col = (r_col != '0) ? r_col - 1'b1 : r_col;
    assign w_bs_off = w_off - AW'(r_col != '0);

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_addr     = r_addr;
        n_waddr    = r_waddr;
        n_wpend    = 1'b0;
        n_fill     = r_fill;
        n_done     = 1'b0;
        n_cell     = '0;
        w_step_row = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_waddr;
        w_wdata    = r_fill;
        w_re       = 1'b0;
        w_raddr    = w_off;

        unique case (r_state) inside
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_kind)
                        KIND_PUT: begin
                            // The blank used if this character scrolls the screen.
                            n_fill = '{attr: {i_back_color, 4'h0}, chr: CODE_SPACE};
                            if (i_char_code == CODE_NEWLINE) begin
                                n_col      = '0;
                                w_step_row = 1'b1;
                            end else if (i_char_code == CODE_BACKSPACE) begin
                                // Read the cell first so its attribute is kept.
                                n_col   = w_bs_col;
                                w_re    = 1'b1;
                                w_raddr = w_bs_off;
                                n_waddr = w_bs_off;
                                n_state = S_BS;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_off;
                                w_wdata = '{attr: {i_back_color, i_fore_color},
                                            chr: i_char_code};
                                if (r_col == LAST_COL) begin
                                    n_col      = '0;
                                    w_step_row = 1'b1;
                                end else begin
                                    n_col  = r_col + 1'b1;
                                    n_done = 1'b1;
                                end
                            end
                            if (w_step_row) begin
                                if (r_row == LAST_ROW) begin
                                    n_addr  = SRC_START;
                                    n_waddr = '0;
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row  = r_row + 1'b1;
                                    n_done = 1'b1;
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            n_fill  = '{attr: {i_back_color, ATTR_CLEAR_FORE}, chr: CODE_NUL};
                            n_waddr = '0;
                            n_state = S_FILL;
                        end
                        KIND_SETPOS: begin
                            n_col  = (int'(i_new_column) < COLUMNS) ? CW'(i_new_column)
                                                                     : LAST_COL;
                            n_row  = (int'(i_new_row) < ROWS) ? RW'(i_new_row) : LAST_ROW;
                            n_done = 1'b1;
                        end
                        KIND_READ: begin
                            if (int'(i_read_index) < CELLS) begin
                                w_re    = 1'b1;
                                w_raddr = AW'(i_read_index);
                                n_state = S_READ;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_cell  = w_rdata;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_BS: begin
                w_we    = 1'b1;
                w_wdata = '{attr: w_rdata.attr, chr: CODE_SPACE};
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SCROLL: begin
                // Reads run one row ahead of writes; each read is written back
                // one row up in the following cycle.
                if (r_addr < SRC_STOP) begin
                    w_re    = 1'b1;
                    w_raddr = r_addr[AW-1:0];
                    n_addr  = r_addr + 1'b1;
                    n_wpend = 1'b1;
                end
                if (r_wpend) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                    n_waddr = r_waddr + 1'b1;
                    if (r_waddr == SCROLL_END) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_INIT, S_FILL: begin
                w_we = 1'b1;
                if (r_waddr == LAST_CELL) begin
                    n_done  = (r_state == S_FILL);
                    n_state = S_IDLE;
                end else begin
                    n_waddr = r_waddr + 1'b1;
                end
            end
            default: begin
                n_waddr = '0;
                n_fill  = '0;
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_col   <= '0;
            r_row   <= '0;
            r_addr  <= '0;
            r_waddr <= '0;
            r_wpend <= 1'b0;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_addr  <= n_addr;
            r_waddr <= n_waddr;
            r_wpend <= n_wpend;
            r_fill  <= n_fill;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_cursor_column = 7'(r_col);
    assign o_cursor_row    = 5'(r_row);
    assign o_cursor_offset = 11'(w_off);
    assign o_cell_char     = r_cell.chr;
    assign o_cell_attr     = r_cell.attr;

    // A result is only ever shown once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    // The cursor always stays on the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= LAST_COL) && (r_row <= LAST_ROW))
        else $error("cursor off screen");

    // Set position raises its result strobe in the cycle after it is accepted.
    a_setpos_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_kind == KIND_SETPOS)) |=> r_done)
        else $error("set position result missing");

    // During a scroll the write pointer trails the read pointer.
    a_scroll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL) |-> ({1'b0, r_waddr} < r_addr))
        else $error("scroll write overtook read");

endmodule
